>>> hw/rtl/salc_pkg.sv
// Shared types, codes and helpers for the set-associative LRU cache model.
// Used by salc_store, salc_scan and set_associative_lru_cache_sim.
`default_nettype none

package salc_pkg;

    // Default geometry, handed to the top level as parameter defaults.
    localparam int DefMaxSets  = 64;
    localparam int DefMaxWays  = 4;
    localparam int DefTagWidth = 32;
    localparam int DefAddrWidth = 64;

    // Fixed widths of the configuration port and the running totals.
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 6;
    localparam int CntW     = 32;

    // Configuration reset values.
    localparam logic [2:0] SetBitsRst   = 3'd1;
    localparam logic [5:0] BlockBitsRst = 6'd4;
    localparam logic [2:0] WaysRst      = 3'd1;

    // Access types carried by one input item.
    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_STORE  = 2'd1,
        REQ_MODIFY = 2'd2,
        REQ_IFETCH = 2'd3
    } t_req;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_SET_BITS   = 2'd0,
        CFG_BLOCK_BITS = 2'd1,
        CFG_WAYS       = 2'd2
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_UPDATE,
        ST_OUT
    } t_state;

    // Control from the sequencer to the way scanner.
    typedef struct packed {
        logic clear;
        logic step;
    } t_scan_ctl;

    // Outcome flags of a completed way scan.
    typedef struct packed {
        logic found;
        logic have_inv;
    } t_scan_flags;

    // Index width for n entries, never below one bit.
    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // Saturating increment of a running total.
    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
        return (v == {CntW{1'b1}}) ? v : v + {{(CntW-1){1'b0}}, 1'b1};
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/salc_store.sv
// Line store: one row per set holding the tags and ages of all ways, plus
// per-line valid flags that reset clears. Depends on salc_pkg.
`default_nettype none

module salc_store #(
    parameter int MAX_SETS  = salc_pkg::DefMaxSets,
    parameter int MAX_WAYS  = salc_pkg::DefMaxWays,
    parameter int TAG_WIDTH = salc_pkg::DefTagWidth
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  logic                                                 i_rd_en,
    input  logic [salc_pkg::idx_width(MAX_SETS)-1:0]             i_rd_set,
    output logic [MAX_WAYS*TAG_WIDTH-1:0]                        o_rd_tags,
    output logic [MAX_WAYS*salc_pkg::idx_width(MAX_WAYS)-1:0]    o_rd_ages,
    output logic [MAX_WAYS-1:0]                                  o_rd_valid,
    input  logic                                                 i_wr_en,
    input  logic [salc_pkg::idx_width(MAX_SETS)-1:0]             i_wr_set,
    input  logic [MAX_WAYS*TAG_WIDTH-1:0]                        i_wr_tags,
    input  logic [MAX_WAYS*salc_pkg::idx_width(MAX_WAYS)-1:0]    i_wr_ages,
    input  logic [MAX_WAYS-1:0]                                  i_wr_valid
);
    import salc_pkg::*;

    localparam int AGE_W = idx_width(MAX_WAYS);

    logic [MAX_WAYS*TAG_WIDTH-1:0] r_tag_mem [MAX_SETS];
    logic [MAX_WAYS*AGE_W-1:0]     r_age_mem [MAX_SETS];
    logic [MAX_WAYS-1:0]           r_valid   [MAX_SETS];
    logic [MAX_WAYS*TAG_WIDTH-1:0] r_rd_tags;
    logic [MAX_WAYS*AGE_W-1:0]     r_rd_ages;
    logic [MAX_WAYS-1:0]           r_rd_valid;

    // Tag and age rows: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_tag_mem[i_wr_set] <= i_wr_tags;
            r_age_mem[i_wr_set] <= i_wr_ages;
        end
        if (i_rd_en) begin
            r_rd_tags  <= r_tag_mem[i_rd_set];
            r_rd_ages  <= r_age_mem[i_rd_set];
            r_rd_valid <= r_valid[i_rd_set];
        end
    end

    // Valid flags live in flip-flops so that reset empties the cache at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < MAX_SETS; s++) begin
                r_valid[s] <= '0;
            end
        end else if (i_wr_en) begin
            r_valid[i_wr_set] <= i_wr_valid;
        end
    end

    assign o_rd_tags  = r_rd_tags;
    assign o_rd_ages  = r_rd_ages;
    assign o_rd_valid = r_rd_valid;

endmodule

`default_nettype wire

>>> hw/rtl/salc_scan.sv
// Way scanner: one shared tag and age comparator that visits one way per
// step and keeps the hit, first invalid and oldest way. Depends on salc_pkg.
`default_nettype none

module salc_scan #(
    parameter int MAX_WAYS  = salc_pkg::DefMaxWays,
    parameter int TAG_WIDTH = salc_pkg::DefTagWidth
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  salc_pkg::t_scan_ctl                               i_ctl,
    input  logic [salc_pkg::idx_width(MAX_WAYS)-1:0]          i_way,
    input  logic [MAX_WAYS*TAG_WIDTH-1:0]                     i_tags,
    input  logic [MAX_WAYS*salc_pkg::idx_width(MAX_WAYS)-1:0] i_ages,
    input  logic [MAX_WAYS-1:0]                               i_valid,
    input  logic [TAG_WIDTH-1:0]                              i_tag,
    output salc_pkg::t_scan_flags                             o_flags,
    output logic [salc_pkg::idx_width(MAX_WAYS)-1:0]          o_hit_way,
    output logic [salc_pkg::idx_width(MAX_WAYS)-1:0]          o_inv_way,
    output logic [salc_pkg::idx_width(MAX_WAYS)-1:0]          o_lru_way,
    output logic [salc_pkg::idx_width(MAX_WAYS)-1:0]          o_hit_age,
    output logic [salc_pkg::idx_width(MAX_WAYS)-1:0]          o_lru_age
);
    import salc_pkg::*;

    localparam int WAY_W = idx_width(MAX_WAYS);
    localparam int AGE_W = idx_width(MAX_WAYS);

    logic [TAG_WIDTH-1:0] sel_tag;
    logic [AGE_W-1:0]     sel_age;
    logic                 sel_valid;
    logic                 tag_eq;
    logic                 r_found;
    logic                 r_have_inv;
    logic [WAY_W-1:0]     r_hit_way;
    logic [WAY_W-1:0]     r_inv_way;
    logic [WAY_W-1:0]     r_lru_way;
    logic [AGE_W-1:0]     r_hit_age;
    logic [AGE_W-1:0]     r_lru_age;

    // Select the current way and compare it against the requested tag.
    always_comb begin
        sel_tag   = i_tags[i_way*TAG_WIDTH +: TAG_WIDTH];
        sel_age   = i_ages[i_way*AGE_W +: AGE_W];
        sel_valid = i_valid[i_way];
        tag_eq    = sel_valid && (sel_tag == i_tag);
    end

    // Search flags restart at the beginning of every access.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found    <= 1'b0;
            r_have_inv <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found    <= 1'b0;
            r_have_inv <= 1'b0;
        end else if (i_ctl.step) begin
            if (!r_found && tag_eq) begin
                r_found <= 1'b1;
            end
            if (!r_have_inv && !sel_valid) begin
                r_have_inv <= 1'b1;
            end
        end
    end

    // Way numbers and ages found so far; the lowest way wins age ties.
    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            if (!r_found && tag_eq) begin
                r_hit_way <= i_way;
                r_hit_age <= sel_age;
            end
            if (!r_have_inv && !sel_valid) begin
                r_inv_way <= i_way;
            end
            if ((i_way == '0) || (sel_age > r_lru_age)) begin
                r_lru_way <= i_way;
                r_lru_age <= sel_age;
            end
        end
    end

    assign o_flags.found    = r_found;
    assign o_flags.have_inv = r_have_inv;
    assign o_hit_way        = r_hit_way;
    assign o_inv_way        = r_inv_way;
    assign o_lru_way        = r_lru_way;
    assign o_hit_age        = r_hit_age;
    assign o_lru_age        = r_lru_age;

endmodule

`default_nettype wire

>>> hw/rtl/set_associative_lru_cache_sim.sv
// Top level of the set-associative cache model with true LRU replacement.
// Depends on salc_pkg, salc_store and salc_scan.
`default_nettype none

// A user-level view of this block: each input item is one access (load,
// store, modify or instruction fetch) at a byte address. Load and store give
// one result item, modify gives two (the second always hits) and an
// instruction fetch gives none. The block handles one item at a time. For
// each access the set row is read from memory, a single tag and age
// comparator then visits the W ways in use one way per cycle (W being the
// associativity in use), and the updated row is written back before the
// result is offered; the second access of a modify starts again with the
// row read once the first result is taken. The next item is accepted in the
// cycle after the last result is taken. The cache is empty after reset with
// no clearing pass. Configuration is taken at any time on a port that is
// always ready.

module set_associative_lru_cache_sim #(
    parameter int MAX_SETS   = salc_pkg::DefMaxSets,
    parameter int MAX_WAYS   = salc_pkg::DefMaxWays,
    parameter int TAG_WIDTH  = salc_pkg::DefTagWidth,
    parameter int ADDR_WIDTH = salc_pkg::DefAddrWidth
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write channel.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [salc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [salc_pkg::CfgDataW-1:0] i_cfg_data,
    // Access channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_req_type,
    input  logic [ADDR_WIDTH-1:0]         i_address,
    // Result channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_was_hit,
    output logic                          o_was_miss,
    output logic                          o_was_evict,
    output logic                          o_last,
    output logic [salc_pkg::CntW-1:0]     o_hit_total,
    output logic [salc_pkg::CntW-1:0]     o_miss_total,
    output logic [salc_pkg::CntW-1:0]     o_evict_total
);
    import salc_pkg::*;

    localparam int SET_W  = idx_width(MAX_SETS);
    localparam int WAY_W  = idx_width(MAX_WAYS);
    localparam int AGE_W  = idx_width(MAX_WAYS);
    localparam int SMAX   = $clog2(MAX_SETS + 1) - 1;
    localparam int SHIFT_W = 7;
    localparam logic [AGE_W-1:0] AgeMax = AGE_W'(MAX_WAYS - 1);

    // Configuration registers.
    logic [2:0] r_cfg_set;
    logic [5:0] r_cfg_block;
    logic [2:0] r_cfg_ways;

    // Sequencer and access registers.
    t_state                r_state;
    t_state                n_state;
    logic [ADDR_WIDTH-1:0] r_addr;
    logic                  r_is_modify;
    logic                  r_pass;
    logic [SET_W-1:0]      r_set;
    logic [TAG_WIDTH-1:0]  r_tag;
    logic [WAY_W-1:0]      r_way;

    // Result and totals.
    logic            r_out_hit;
    logic            r_out_miss;
    logic            r_out_evict;
    logic            r_out_last;
    logic [CntW-1:0] r_hits;
    logic [CntW-1:0] r_misses;
    logic [CntW-1:0] r_evicts;

    // Decoded configuration and address fields.
    logic [SET_W-1:0]      eff_set_bits;
    logic [WAY_W-1:0]      ways_m1;
    logic [SET_W-1:0]      set_mask;
    logic [ADDR_WIDTH-1:0] addr_shr;
    logic [SET_W-1:0]      set_idx;
    logic [SHIFT_W-1:0]    tag_shift;
    logic [TAG_WIDTH-1:0]  tag_val;

    // Sequencer outputs.
    logic      in_stall;
    logic      out_valid;
    logic      rd_en;
    logic      wr_en;
    logic      accept;
    logic      out_take;
    t_scan_ctl scan_ctl;

    // Store and scanner connections.
    logic [MAX_WAYS*TAG_WIDTH-1:0] rd_tags;
    logic [MAX_WAYS*AGE_W-1:0]     rd_ages;
    logic [MAX_WAYS-1:0]           rd_valid;
    logic [MAX_WAYS*TAG_WIDTH-1:0] wr_tags;
    logic [MAX_WAYS*AGE_W-1:0]     wr_ages;
    logic [MAX_WAYS-1:0]           wr_valid;
    t_scan_flags                   scan_flags;
    logic [WAY_W-1:0]              hit_way;
    logic [WAY_W-1:0]              inv_way;
    logic [WAY_W-1:0]              lru_way;
    logic [AGE_W-1:0]              hit_age;
    logic [AGE_W-1:0]              lru_age;
    logic [WAY_W-1:0]              victim;
    logic [AGE_W-1:0]              old_age;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_set   <= SetBitsRst;
            r_cfg_block <= BlockBitsRst;
            r_cfg_ways  <= WaysRst;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SET_BITS:   r_cfg_set   <= i_cfg_data[2:0];
                CFG_BLOCK_BITS: r_cfg_block <= i_cfg_data;
                CFG_WAYS:       r_cfg_ways  <= i_cfg_data[2:0];
                default:        r_cfg_set   <= r_cfg_set;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Effective set bits and associativity, clamped to the built geometry.
    always_comb begin
        if (int'(r_cfg_set) > SMAX) begin
            eff_set_bits = SET_W'(SMAX);
        end else begin
            eff_set_bits = SET_W'(r_cfg_set);
        end
        if (r_cfg_ways == 3'd0) begin
            ways_m1 = '0;
        end else if (int'(r_cfg_ways) > MAX_WAYS) begin
            ways_m1 = WAY_W'(MAX_WAYS - 1);
        end else begin
            ways_m1 = WAY_W'(r_cfg_ways - 3'd1);
        end
    end

    // Split the address into set index and tag.
    always_comb begin
        set_mask  = ~({SET_W{1'b1}} << eff_set_bits);
        addr_shr  = r_addr >> r_cfg_block;
        set_idx   = addr_shr[SET_W-1:0] & set_mask;
        tag_shift = SHIFT_W'(eff_set_bits) + SHIFT_W'(r_cfg_block);
        tag_val   = TAG_WIDTH'(r_addr >> tag_shift);
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state and controls.
    always_comb begin
        n_state   = r_state;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        scan_ctl  = '0;
        case (r_state)
            ST_IDLE: begin
                in_stall = 1'b0;
                if (i_in_valid && (t_req'(i_req_type) != REQ_IFETCH)) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                rd_en          = 1'b1;
                scan_ctl.clear = 1'b1;
                n_state        = ST_SCAN;
            end
            ST_SCAN: begin
                scan_ctl.step = 1'b1;
                if (r_way == ways_m1) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                wr_en   = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = r_out_last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign accept   = i_in_valid && !in_stall;
    assign out_take = out_valid && !i_out_stall;

    // Control registers of the running access.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass      <= 1'b0;
            r_way       <= '0;
            r_is_modify <= 1'b0;
        end else begin
            if (accept) begin
                r_pass      <= 1'b0;
                r_is_modify <= (t_req'(i_req_type) == REQ_MODIFY);
            end else if (out_take) begin
                r_pass <= 1'b1;
            end
            if (r_state == ST_READ) begin
                r_way <= '0;
            end else if (r_state == ST_SCAN) begin
                r_way <= r_way + WAY_W'(1);
            end
        end
    end

    // Access payload: address, then set and tag for the write back.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= i_address;
        end
        if (r_state == ST_READ) begin
            r_set <= set_idx;
            r_tag <= tag_val;
        end
    end

    salc_store #(
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_set   (set_idx),
        .o_rd_tags  (rd_tags),
        .o_rd_ages  (rd_ages),
        .o_rd_valid (rd_valid),
        .i_wr_en    (wr_en),
        .i_wr_set   (r_set),
        .i_wr_tags  (wr_tags),
        .i_wr_ages  (wr_ages),
        .i_wr_valid (wr_valid)
    );

    salc_scan #(
        .MAX_WAYS  (MAX_WAYS),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (scan_ctl),
        .i_way     (r_way),
        .i_tags    (rd_tags),
        .i_ages    (rd_ages),
        .i_valid   (rd_valid),
        .i_tag     (r_tag),
        .o_flags   (scan_flags),
        .o_hit_way (hit_way),
        .o_inv_way (inv_way),
        .o_lru_way (lru_way),
        .o_hit_age (hit_age),
        .o_lru_age (lru_age)
    );

    // Pick the way to touch and build the updated set row.
    always_comb begin
        if (scan_flags.found) begin
            victim  = hit_way;
            old_age = hit_age;
        end else if (scan_flags.have_inv) begin
            victim  = inv_way;
            old_age = AgeMax;
        end else begin
            victim  = lru_way;
            old_age = lru_age;
        end
        wr_tags  = rd_tags;
        wr_ages  = rd_ages;
        wr_valid = rd_valid;
        // Valid ways in use that are younger than the touched line grow one older.
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (w <= int'(ways_m1)) begin
                if (w == int'(victim)) begin
                    wr_ages[w*AGE_W +: AGE_W] = '0;
                end else if (rd_valid[w] && (rd_ages[w*AGE_W +: AGE_W] < old_age)) begin
                    wr_ages[w*AGE_W +: AGE_W] = rd_ages[w*AGE_W +: AGE_W] + AGE_W'(1);
                end
            end
        end
        if (!scan_flags.found) begin
            wr_tags[victim*TAG_WIDTH +: TAG_WIDTH] = r_tag;
        end
        wr_valid[victim] = 1'b1;
    end

    // Running totals, updated once per access.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits   <= '0;
            r_misses <= '0;
            r_evicts <= '0;
        end else if (r_state == ST_UPDATE) begin
            if (scan_flags.found) begin
                r_hits <= sat_inc(r_hits);
            end else begin
                r_misses <= sat_inc(r_misses);
                if (!scan_flags.have_inv) begin
                    r_evicts <= sat_inc(r_evicts);
                end
            end
        end
    end

    // Result register, held until the item is taken.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPDATE) begin
            r_out_hit   <= scan_flags.found;
            r_out_miss  <= !scan_flags.found;
            r_out_evict <= !scan_flags.found && !scan_flags.have_inv;
            r_out_last  <= !r_is_modify || r_pass;
        end
    end

    assign o_in_stall    = in_stall;
    assign o_out_valid   = out_valid;
    assign o_was_hit     = r_out_hit;
    assign o_was_miss    = r_out_miss;
    assign o_was_evict   = r_out_evict;
    assign o_last        = r_out_last;
    assign o_hit_total   = r_hits;
    assign o_miss_total  = r_misses;
    assign o_evict_total = r_evicts;

    // A result is either a hit or a miss, never both.
    a_hit_xor_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_was_hit ^ o_was_miss))
        else $error("result is not exactly one of hit and miss");

    // An eviction only happens on a miss.
    a_evict_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_was_evict) |-> o_was_miss)
        else $error("eviction reported without a miss");

    // The second access of a modify always finds the line just filled.
    a_modify_second_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE && r_pass) |-> scan_flags.found)
        else $error("second access of a modify missed");

    // A finished result is taken before a new item enters.
    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("input taken while a result is pending");

endmodule

`default_nettype wire

>>> tb/set_associative_lru_cache_sim_tb.sv
// Self-checking testbench for set_associative_lru_cache_sim.
// Needs salc_pkg and the cache RTL; it carries its own LRU cache predictor,
// a directed script followed by randomized phases over several geometries.
`timescale 1ns / 100ps

module set_associative_lru_cache_sim_tb;

    import salc_pkg::*;

    localparam int          SETS            = 64;
    localparam int          WAYS            = 4;
    localparam int          LINES           = SETS * WAYS;
    localparam int          RANDOM_ACCESSES = 1530;
    localparam int          SETTLE_CYCLES   = 8;
    localparam int          TAIL_CYCLES     = 20;
    localparam int unsigned IDLE_LIMIT      = 2000;
    localparam int          MAX_REPORTS     = 10;

    // One result item: access outcome plus the running totals after it.
    typedef struct packed {
        logic            hit;
        logic            miss;
        logic            evict;
        logic            last;
        logic [CntW-1:0] hits;
        logic [CntW-1:0] misses;
        logic [CntW-1:0] evicts;
    } t_outcome;

    // One line of the directed script: a register write or an access.
    typedef struct {
        bit                  is_reg;
        t_cfg_idx            reg_idx;
        logic [CfgDataW-1:0] reg_val;
        t_req                kind;
        logic [63:0]         addr;
        bit                  typed;
        t_outcome            want;
    } t_step;

    // Pacing modes of the result receiver.
    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_BLOCKED
    } t_rx_mode;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    logic [1:0]          i_req_type  = '0;
    logic [63:0]         i_address   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_was_hit;
    logic                o_was_miss;
    logic                o_was_evict;
    logic                o_last;
    logic [CntW-1:0]     o_hit_total;
    logic [CntW-1:0]     o_miss_total;
    logic [CntW-1:0]     o_evict_total;

    // Predictor copy of the cache contents, totals and geometry.
    bit              live[LINES];
    bit [31:0]       tag_store[LINES];
    bit [1:0]        age_store[LINES];
    bit [CntW-1:0]   hit_count   = '0;
    bit [CntW-1:0]   miss_count  = '0;
    bit [CntW-1:0]   evict_count = '0;
    logic [2:0]      cfg_set_bits   = SetBitsRst;
    logic [5:0]      cfg_block_bits = BlockBitsRst;
    logic [2:0]      cfg_ways       = WaysRst;

    t_outcome        outcome_q[$];
    int unsigned     mismatches   = 0;
    int unsigned     results_seen = 0;
    int unsigned     quiet_cycles = 0;
    t_rx_mode        rx_mode      = RX_FREE;
    int unsigned     rx_left      = 0;

    set_associative_lru_cache_sim i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_address     (i_address),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_was_hit     (o_was_hit),
        .o_was_miss    (o_was_miss),
        .o_was_evict   (o_was_evict),
        .o_last        (o_last),
        .o_hit_total   (o_hit_total),
        .o_miss_total  (o_miss_total),
        .o_evict_total (o_evict_total)
    );

    // 10 ns clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [CntW-1:0] bump(logic [CntW-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Set index width actually used: no more sets than the cache holds.
    function automatic int unsigned index_bits();
        return (cfg_set_bits > 3'd6) ? 6 : cfg_set_bits;
    endfunction

    // One lookup with true LRU update; returns flags and new totals.
    function automatic t_outcome lookup_line(logic [63:0] addr);
        t_outcome    o;
        int unsigned s, b, ways, base, victim, prior_age;
        logic [31:0] tg;
        bit          found, have_inv;
        s = index_bits();
        b = cfg_block_bits;
        ways = (cfg_ways == 3'd0) ? 1 : ((cfg_ways > WAYS) ? WAYS : cfg_ways);
        base = 32'((addr >> b) & ((64'd1 << s) - 64'd1)) * WAYS;
        tg = (s + b >= 64) ? '0 : 32'(addr >> (s + b));
        o = '0;
        found = 0;
        have_inv = 0;
        victim = 0;
        for (int w = 0; w < ways; w++) begin
            if (!found && live[base + w] && tag_store[base + w] == tg) begin
                victim = w;
                found = 1;
            end
        end
        if (found) begin
            o.hit = 1'b1;
            hit_count = bump(hit_count);
            prior_age = age_store[base + victim];
        end else begin
            o.miss = 1'b1;
            miss_count = bump(miss_count);
            for (int w = 0; w < ways; w++) begin
                if (!have_inv && !live[base + w]) begin
                    victim = w;
                    have_inv = 1;
                end
            end
            if (have_inv) begin
                prior_age = WAYS - 1;
            end else begin
                // Oldest way goes; ties resolve to the lowest index.
                victim = 0;
                for (int w = 1; w < ways; w++) begin
                    if (age_store[base + w] > age_store[base + victim])
                        victim = w;
                end
                o.evict = 1'b1;
                evict_count = bump(evict_count);
                prior_age = age_store[base + victim];
            end
            live[base + victim] = 1;
            tag_store[base + victim] = tg;
        end
        // Age every younger valid way in use, then make the touched way newest.
        for (int w = 0; w < ways; w++) begin
            if (w != victim && live[base + w] && age_store[base + w] < prior_age)
                age_store[base + w] = age_store[base + w] + 1'b1;
        end
        age_store[base + victim] = '0;
        o.hits = hit_count;
        o.misses = miss_count;
        o.evicts = evict_count;
        return o;
    endfunction

    function automatic string show(t_outcome o);
        return $sformatf("hit=%0b miss=%0b evict=%0b last=%0b totals=%0d/%0d/%0d",
                         o.hit, o.miss, o.evict, o.last, o.hits, o.misses, o.evicts);
    endfunction

    function automatic t_outcome outcome(bit h, bit m, bit e, int ht, int mt, int et);
        t_outcome o;
        o.hit = h;
        o.miss = m;
        o.evict = e;
        o.last = 1'b1;
        o.hits = ht;
        o.misses = mt;
        o.evicts = et;
        return o;
    endfunction

    function automatic t_step access_step(t_req kind, logic [63:0] addr);
        t_step st;
        st.is_reg = 0;
        st.reg_idx = CFG_SET_BITS;
        st.reg_val = '0;
        st.kind = kind;
        st.addr = addr;
        st.typed = 0;
        st.want = '0;
        return st;
    endfunction

    function automatic t_step known_step(t_req kind, logic [63:0] addr, t_outcome want);
        t_step st;
        st = access_step(kind, addr);
        st.typed = 1;
        st.want = want;
        return st;
    endfunction

    function automatic t_step reg_step(t_cfg_idx idx, int val);
        t_step st;
        st = access_step(REQ_LOAD, '0);
        st.is_reg = 1;
        st.reg_idx = idx;
        st.reg_val = CfgDataW'(val);
        return st;
    endfunction

    // Sender idle gap: mostly none or short, now and then long.
    function automatic int unsigned item_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Addresses clustered on a few tags of two neighboring sets, plus noise.
    function automatic logic [63:0] pick_address(logic [63:0] base);
        int unsigned s, b;
        logic [63:0] a;
        if ($urandom_range(0, 99) < 12) return {$urandom, $urandom};
        s = index_bits();
        b = cfg_block_bits;
        a = base ^ (64'($urandom_range(0, 5)) << (s + b)) ^ (64'($urandom_range(0, 1)) << b);
        return a ^ ({$urandom, $urandom} & ((64'd1 << b) - 64'd1));
    endfunction

    // Present one access item, hold it until taken, then predict its results.
    task automatic offer_access(t_req kind, logic [63:0] addr, bit typed, t_outcome want);
        int unsigned gap, count;
        t_outcome    o;
        gap = item_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_address  <= addr;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        if (kind != REQ_IFETCH) begin
            count = (kind == REQ_MODIFY) ? 2 : 1;
            for (int k = 0; k < count; k++) begin
                o = lookup_line(addr);
                o.last = (k == count - 1);
                outcome_q.push_back(o);
            end
            if (typed)
                outcome_q[$] = want;
        end
    endtask

    // Write one register; the caller lowers the valid after the last write.
    task automatic write_reg(t_cfg_idx idx, logic [CfgDataW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            CFG_SET_BITS:   cfg_set_bits = val[2:0];
            CFG_BLOCK_BITS: cfg_block_bits = val[5:0];
            CFG_WAYS:       cfg_ways = val[2:0];
            default: ;
        endcase
    endtask

    // Let the block run dry, including any trailing instruction fetch.
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver pacing: stretches free, lightly or heavily stalled, or blocked.
    always @(posedge i_clk) begin : rx_pacing
        int unsigned r;
        if (rx_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 35)
                rx_mode = RX_FREE;
            else if (r < 70)
                rx_mode = RX_LIGHT;
            else if (r < 95)
                rx_mode = RX_HEAVY;
            else
                rx_mode = RX_BLOCKED;
            rx_left = (rx_mode == RX_BLOCKED) ? $urandom_range(10, 40) : $urandom_range(5, 60);
        end else begin
            rx_left = rx_left - 1;
        end
        case (rx_mode)
            RX_FREE:  i_out_stall <= 1'b0;
            RX_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: i_out_stall <= ($urandom_range(0, 9) < 7);
            default:  i_out_stall <= 1'b1;
        endcase
    end

    // Compare each taken result with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_outcome got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_was_hit, o_was_miss, o_was_evict, o_last,
                   o_hit_total, o_miss_total, o_evict_total};
            results_seen = results_seen + 1;
            if (outcome_q.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d arrived with nothing expected: %s",
                             results_seen, show(got));
            end else begin
                want = outcome_q.pop_front();
                if (got !== want) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result %0d mismatch, expected %s", results_seen, show(want));
                        $display("result %0d mismatch, actual   %s", results_seen, show(got));
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which no channel moves an item.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("set_associative_lru_cache_sim verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_step       script[$];
        bit          in_reg_run;
        int unsigned done_accesses, phase, phase_len, n;
        t_req        kind;
        logic [63:0] base;
        int unsigned s_val, b_val, w_val, r;

        // Reset geometry: two sets, 16-byte blocks, direct mapped.
        script.push_back(known_step(REQ_LOAD, 64'h0, outcome(0, 1, 0, 0, 1, 0)));
        script.push_back(known_step(REQ_STORE, 64'h8, outcome(1, 0, 0, 1, 1, 0)));
        script.push_back(known_step(REQ_LOAD, 64'h10, outcome(0, 1, 0, 1, 2, 0)));
        script.push_back(known_step(REQ_LOAD, 64'h20, outcome(0, 1, 1, 1, 3, 1)));
        script.push_back(access_step(REQ_IFETCH, '1));
        script.push_back(access_step(REQ_MODIFY, '1));
        script.push_back(known_step(REQ_LOAD, '1, outcome(1, 0, 0, 3, 4, 2)));
        // Tags alias when addresses differ only above the kept tag bits.
        script.push_back(access_step(REQ_LOAD, 64'h10));
        script.push_back(access_step(REQ_LOAD, 64'h8000_0000_0000_0010));
        // Oversized set and way counts saturate; no block offset; old lines stay.
        script.push_back(reg_step(CFG_SET_BITS, 7));
        script.push_back(reg_step(CFG_BLOCK_BITS, 0));
        script.push_back(reg_step(CFG_WAYS, 7));
        script.push_back(access_step(REQ_LOAD, 64'h40));
        script.push_back(access_step(REQ_LOAD, 64'h0));
        script.push_back(access_step(REQ_LOAD, 64'h80));
        script.push_back(access_step(REQ_STORE, 64'hC0));
        script.push_back(access_step(REQ_LOAD, 64'h100));
        // Build an age tie in set 5 by shrinking and regrowing the ways.
        script.push_back(reg_step(CFG_WAYS, 2));
        script.push_back(access_step(REQ_LOAD, 64'h05));
        script.push_back(access_step(REQ_LOAD, 64'h45));
        script.push_back(reg_step(CFG_WAYS, 1));
        script.push_back(access_step(REQ_LOAD, 64'h85));
        script.push_back(reg_step(CFG_WAYS, 2));
        script.push_back(access_step(REQ_LOAD, 64'hC5));
        script.push_back(access_step(REQ_LOAD, 64'h45));
        script.push_back(access_step(REQ_LOAD, 64'h85));
        // Widest offset leaves no tag bits at all.
        script.push_back(reg_step(CFG_BLOCK_BITS, 63));
        script.push_back(access_step(REQ_LOAD, 64'h7FFF_FFFF_FFFF_FFFF));
        script.push_back(access_step(REQ_LOAD, 64'h8000_0000_0000_0000));
        // One set and zero ways.
        script.push_back(reg_step(CFG_SET_BITS, 0));
        script.push_back(reg_step(CFG_WAYS, 0));
        script.push_back(access_step(REQ_MODIFY, 64'h0123_4567_89AB_CDEF));
        script.push_back(access_step(REQ_STORE, '1));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed script.
        in_reg_run = 0;
        foreach (script[i]) begin
            if (script[i].is_reg) begin
                if (!in_reg_run)
                    quiesce();
                in_reg_run = 1;
                write_reg(script[i].reg_idx, script[i].reg_val);
            end else begin
                if (in_reg_run)
                    i_cfg_valid <= 1'b0;
                in_reg_run = 0;
                offer_access(script[i].kind, script[i].addr, script[i].typed, script[i].want);
            end
        end

        // Random phases, each with its own geometry and address cluster.
        done_accesses = 0;
        phase = 0;
        while (done_accesses < RANDOM_ACCESSES) begin
            case (phase)
                0: begin s_val = 0; b_val = 0;  w_val = 1; end
                1: begin s_val = 7; b_val = 63; w_val = 7; end
                2: begin s_val = 6; b_val = 32; w_val = 4; end
                3: begin s_val = 1; b_val = 1;  w_val = 0; end
                default: begin
                    s_val = $urandom_range(0, 7);
                    w_val = $urandom_range(0, 7);
                    r = $urandom_range(0, 9);
                    if (r < 7)
                        b_val = $urandom_range(0, 8);
                    else if (r < 9)
                        b_val = $urandom_range(9, 40);
                    else
                        b_val = $urandom_range(41, 63);
                end
            endcase
            quiesce();
            write_reg(CFG_SET_BITS, CfgDataW'(s_val));
            write_reg(CFG_BLOCK_BITS, CfgDataW'(b_val));
            write_reg(CFG_WAYS, CfgDataW'(w_val));
            i_cfg_valid <= 1'b0;
            base = {$urandom, $urandom};
            phase_len = $urandom_range(60, 140);
            n = 0;
            while (n < phase_len && done_accesses < RANDOM_ACCESSES) begin
                if ($urandom_range(0, 9) == 0)
                    kind = REQ_IFETCH;
                else
                    kind = t_req'($urandom_range(0, 2));
                offer_access(kind, pick_address(base), 1'b0, '0);
                n = n + 1;
                done_accesses = done_accesses + 1;
            end
            phase = phase + 1;
        end

        // Drain, then give stray results a chance to show up.
        i_in_valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outcome_q.size() == 0)
            $display("set_associative_lru_cache_sim verification clean");
        else
            $display("set_associative_lru_cache_sim verification failed");
        $finish;
    end

endmodule
